// ----- sv/tsd_pkg.sv -----
package tsd_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int MAX_NODES  = 128;
  localparam int TREE_DEPTH = 64;
  localparam int SLOT_W     = 3;
  localparam int NODE_W     = 7;
  localparam int CELL_W     = SLOT_W + NODE_W;
  localparam int CELLS      = NUM_SLOTS * MAX_NODES;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_NODE   = 2'd1;
  localparam logic [1:0] KIND_DERIVE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SUB   = 2'd1;
  localparam logic [1:0] ST_NO_NODE  = 2'd2;

  typedef struct packed {
    logic [6:0]  level;
    logic [63:0] index;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
  } node_t;

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[i];
  endfunction

  localparam logic [255:0] SHA_INIT = {
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

endpackage

// ----- sv/tree_subkey_derivation.sv -----
// Load transactions write a slot header or node and return a status; derive searches
// the slot's nodes in order, then hashes per tree level (worst case: 128 nodes, 64 levels).
// Throughput: one transaction at a time, set by node memory reads and the
// single SHA-256 round unit (one round per cycle); a new input is accepted only after the result is taken.
// Reset: synchronous; clears slot headers and control; node memory is not cleared.
module tree_subkey_derivation
  import tsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // slot_number, slot_enable, node_total, node_number, channel_id, node_depth,
  // node_position, key_upper, key_lower, time_stamp (314 bits, zero pad)
  input  logic [319:0] s_tdata,
  input  logic [1:0]   s_tuser,   // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata    // status, leaf_key_upper, leaf_key_lower, zero pad
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SLOT  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_HASH  = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [1:0]  kind;
  logic [2:0]  in_slot;
  logic        in_en;
  logic [7:0]  in_total;
  logic [6:0]  in_node;
  logic [31:0] in_chan;
  logic [6:0]  in_depth;
  logic [63:0] in_pos, in_khi, in_klo, in_ts;

  assign in_slot  = s_tdata[2:0];
  assign in_en    = s_tdata[3];
  assign in_total = s_tdata[11:4];
  assign in_node  = s_tdata[18:12];
  assign in_chan  = s_tdata[50:19];
  assign in_depth = s_tdata[57:51];
  assign in_pos   = s_tdata[121:58];
  assign in_khi   = s_tdata[185:122];
  assign in_klo   = s_tdata[249:186];
  assign in_ts    = s_tdata[313:250];
  assign kind     = s_tuser;

  logic [NUM_SLOTS-1:0] slot_active;
  logic [31:0] slot_channel [NUM_SLOTS];
  logic [7:0]  slot_node_count [NUM_SLOTS];

  node_t node_mem [CELLS];
  node_t rd_node;
  logic [CELL_W-1:0] rd_addr;

  logic [31:0] chan;
  logic [63:0] ts;
  logic [2:0]  sl;
  logic [7:0]  cnt, nidx;
  logic [6:0]  lv;
  logic [63:0] idx, khi, klo;
  logic [1:0]  st_res;
  logic [127:0] res_key;

  logic        sha_start, sha_done;
  logic [255:0] dig;

  tsd_sha256 u_sha (
    .clk(clk), .rst(rst), .start(sha_start), .msg({khi, klo}),
    .done(sha_done), .digest(dig)
  );

  logic [6:0]  shamt;
  logic [63:0] r_start, r_end, c_start, c_end;
  assign shamt = 7'(TREE_DEPTH) - lv;

  always_comb begin
    c_start = (rd_node.level > 7'(TREE_DEPTH) || (7'(TREE_DEPTH) - rd_node.level) >= 7'd64)
              ? 64'd0 : rd_node.index << (7'(TREE_DEPTH) - rd_node.level);
    c_end   = ((7'(TREE_DEPTH) - rd_node.level) >= 7'd64)
              ? 64'hffff_ffff_ffff_ffff
              : ((rd_node.index + 64'd1) << (7'(TREE_DEPTH) - rd_node.level)) - 64'd1;
    r_start = (shamt >= 7'd64) ? 64'd0 : idx << shamt;
    r_end   = (shamt >= 7'd64) ? 64'hffff_ffff_ffff_ffff
                               : ((idx + 64'd1) << shamt) - 64'd1;
  end

  logic                 hit;
  logic [SLOT_W-1:0]    hit_slot;
  always_comb begin
    hit = 1'b0;
    hit_slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (slot_active[i] && slot_channel[i] == chan) begin
        hit = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  logic s_acc;
  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (s_acc && kind == KIND_NODE && {1'b0, in_node} < 8'(MAX_NODES)) begin
      node_mem[{in_slot, in_node}] <= '{in_depth, in_pos, in_khi, in_klo};
    end
    rd_node <= node_mem[rd_addr];
  end

  assign rd_addr = {sl, nidx[NODE_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_active <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_channel[i] <= '0;
        slot_node_count[i] <= '0;
      end
      m_tvalid <= 1'b0;
      sha_start <= 1'b0;
    end else begin
      sha_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            chan <= in_chan;
            ts <= in_ts;
            st_res <= ST_OK;
            res_key <= '0;
            if (kind == KIND_HEADER) begin
              slot_active[in_slot] <= in_en;
              slot_channel[in_slot] <= in_chan;
              slot_node_count[in_slot] <= in_total;
            end
            state <= (kind == KIND_DERIVE) ? S_SLOT : S_OUT;
          end
        end
        S_SLOT: begin
          sl <= hit_slot;
          nidx <= '0;
          cnt <= (slot_node_count[hit_slot] > 8'(MAX_NODES)) ? 8'(MAX_NODES)
                                                             : slot_node_count[hit_slot];
          if (!hit) begin
            st_res <= ST_NO_SUB;
            state <= S_OUT;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: begin
          if (nidx >= cnt) begin
            st_res <= ST_NO_NODE;
            state <= S_OUT;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (rd_node.level <= 7'(TREE_DEPTH) && ts >= c_start && ts <= c_end) begin
            lv <= rd_node.level;
            idx <= rd_node.index;
            khi <= rd_node.key_hi;
            klo <= rd_node.key_lo;
            state <= S_HASH;
          end else begin
            nidx <= nidx + 8'd1;
            state <= S_RD;
          end
        end
        S_HASH: begin
          if (lv >= 7'(TREE_DEPTH)) begin
            res_key <= {khi, klo};
            state <= S_OUT;
          end else begin
            sha_start <= 1'b1;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (sha_done) begin
            lv <= lv + 7'd1;
            if (ts - r_start < r_end - ts) begin
              idx <= {idx[62:0], 1'b0};
              {khi, klo} <= dig[255:128];
            end else begin
              idx <= {idx[62:0], 1'b1};
              {khi, klo} <= dig[127:0];
            end
            state <= S_HASH;
          end
        end
        S_OUT: begin
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata <= {6'd0, res_key[63:0], res_key[127:64], st_res};
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[129:2] == '0)
    else $error("nonzero key on failed derive");
  assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT |-> lv < 7'(TREE_DEPTH))
    else $error("hash past leaf level");

endmodule

// ----- sv/tsd_sha256.sv -----
module tsd_sha256
  import tsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] msg,
  output logic         done,
  output logic [255:0] digest
);

  logic [511:0] w;
  logic [31:0]  a, b, c, d, e, f, g, h;
  logic [5:0]   round;
  logic         busy;
  logic         fin;

  logic [31:0] w0, w1, w9, w14, s0, s1, w_new;
  logic [31:0] t1, t2, bs0, bs1, ch, maj;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    w0  = w[511:480];
    w1  = w[479:448];
    w9  = w[223:192];
    w14 = w[63:32];
    s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_new = w0 + s0 + w9 + s1;
    bs1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    ch  = (e & f) ^ (~e & g);
    t1  = h + bs1 + ch + sha_k(round) + w0;
    bs0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    maj = (a & b) ^ (a & c) ^ (b & c);
    t2  = bs0 + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        round <= '0;
        w <= {msg, 32'h80000000, 320'd0, 32'd128};
        {a, b, c, d, e, f, g, h} <= SHA_INIT;
      end else if (busy) begin
        w <= {w[479:0], w_new};
        h <= g; g <= f; f <= e; e <= d + t1;
        d <= c; c <= b; b <= a; a <= t1 + t2;
        round <= round + 6'd1;
        if (round == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        digest <= {a + SHA_INIT[255:224], b + SHA_INIT[223:192],
                   c + SHA_INIT[191:160], d + SHA_INIT[159:128],
                   e + SHA_INIT[127:96],  f + SHA_INIT[95:64],
                   g + SHA_INIT[63:32],   h + SHA_INIT[31:0]};
        done <= 1'b1;
      end
    end
  end

endmodule
